### rtl/core/cnlc_pkg.sv
// cnlc_pkg: types, constants and helper functions of the card number luhn classifier
// used by card_number_luhn_classifier_core; depends on nothing else
package cnlc_pkg;

	// digit store limit and field widths
	localparam int unsigned MAX_DIGITS   = 19;
	localparam int unsigned CHAR_W       = 8;
	localparam int unsigned COUNT_W      = 5;
	localparam int unsigned SUM_W        = 4;
	localparam int unsigned PREFIX_W     = 20;
	localparam int unsigned PREFIX_DIGITS = 6;
	localparam int unsigned OUT_TDATA_W  = 16;

	// card network codes
	typedef enum logic [2:0] {
		NET_UNKNOWN    = 3'd0,
		NET_VISA       = 3'd1,
		NET_MASTERCARD = 3'd2,
		NET_AMEX       = 3'd3,
		NET_DISCOVER   = 3'd4
	} network_t;

	// result word, lowest field last (lowest bits)
	typedef struct packed {
		logic [4:0]         pad;
		logic               overflowed;
		logic               stray_char;
		network_t           network_code;
		logic               check_ok;
		logic [COUNT_W-1:0] num_digits;
	} result_t;

	// six-digit prefix ranges
	localparam logic [PREFIX_W-1:0] VISA_LO   = 20'd400000;
	localparam logic [PREFIX_W-1:0] VISA_HI   = 20'd499999;
	localparam logic [PREFIX_W-1:0] AMEX34_LO = 20'd340000;
	localparam logic [PREFIX_W-1:0] AMEX34_HI = 20'd349999;
	localparam logic [PREFIX_W-1:0] AMEX37_LO = 20'd370000;
	localparam logic [PREFIX_W-1:0] AMEX37_HI = 20'd379999;
	localparam logic [PREFIX_W-1:0] MC5_LO    = 20'd510000;
	localparam logic [PREFIX_W-1:0] MC5_HI    = 20'd559999;
	localparam logic [PREFIX_W-1:0] MC2_LO    = 20'd222100;
	localparam logic [PREFIX_W-1:0] MC2_HI    = 20'd272099;
	localparam logic [PREFIX_W-1:0] DI6011_LO = 20'd601100;
	localparam logic [PREFIX_W-1:0] DI6011_HI = 20'd601199;
	localparam logic [PREFIX_W-1:0] DI65_LO   = 20'd650000;
	localparam logic [PREFIX_W-1:0] DI65_HI   = 20'd659999;
	localparam logic [PREFIX_W-1:0] DI644_LO  = 20'd644000;
	localparam logic [PREFIX_W-1:0] DI644_HI  = 20'd649999;
	localparam logic [PREFIX_W-1:0] DI622_LO  = 20'd622126;
	localparam logic [PREFIX_W-1:0] DI622_HI  = 20'd622925;

	// doubled luhn digit, nine taken off above nine
	function automatic logic [SUM_W-1:0] dbl_digit(input logic [SUM_W-1:0] v);
		logic [SUM_W:0] x;
		x = {v, 1'b0};
		if (x > 5'd9) begin
			x = x - 5'd9;
		end
		return x[SUM_W-1:0];
	endfunction

	// sum of two decimal digits modulo ten
	function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 5'd10) begin
			s = s - 5'd10;
		end
		return s[SUM_W-1:0];
	endfunction

	// whitespace or hyphen
	function automatic logic is_skip(input logic [CHAR_W-1:0] c);
		return (c inside {8'h20, 8'h2D, [8'h09:8'h0D]});
	endfunction

	// allowed card length
	function automatic logic len_ok(input logic [COUNT_W-1:0] n);
		return (n inside {5'd13, 5'd15, 5'd16, 5'd19});
	endfunction

	function automatic logic in_rng(input logic [PREFIX_W-1:0] p,
		input logic [PREFIX_W-1:0] lo, input logic [PREFIX_W-1:0] hi);
		return (p >= lo) && (p <= hi);
	endfunction

	// network from length and six-digit prefix, rules in priority order
	function automatic network_t detect_network(input logic [COUNT_W-1:0] n,
		input logic [PREFIX_W-1:0] p);
		network_t net;
		net = NET_UNKNOWN;
		if (n == 5'd15 && (in_rng(p, AMEX34_LO, AMEX34_HI) ||
			in_rng(p, AMEX37_LO, AMEX37_HI))) begin
			net = NET_AMEX;
		end else if ((n == 5'd13 || n == 5'd16 || n == 5'd19) &&
			in_rng(p, VISA_LO, VISA_HI)) begin
			net = NET_VISA;
		end else if (n == 5'd16 && (in_rng(p, MC5_LO, MC5_HI) ||
			in_rng(p, MC2_LO, MC2_HI))) begin
			net = NET_MASTERCARD;
		end else if ((n == 5'd16 || n == 5'd19) && (in_rng(p, DI6011_LO, DI6011_HI) ||
			in_rng(p, DI65_LO, DI65_HI) || in_rng(p, DI644_LO, DI644_HI) ||
			in_rng(p, DI622_LO, DI622_HI))) begin
			net = NET_DISCOVER;
		end
		return net;
	endfunction

endpackage

### rtl/core/card_number_luhn_classifier_core.sv
// card_number_luhn_classifier_core: luhn check and card network classifier, top level
// depends on cnlc_pkg
// path: an end request is taken into the input register, then its result into the result
// register and onto m_tdata; one request per cycle through the state update between the
// two registers, but an end request waits in the input register while an earlier result
// is not yet taken
// reset: arst_n clears the pipeline valids and all running sums, counts and flags
module card_number_luhn_classifier_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [cnlc_pkg::CHAR_W-1:0]        s_tdata,  // [7:0] character
	input  logic                               s_tlast,  // end of string
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [4:0] num_digits, [5] check_ok, [8:6] network_code,
	// [9] stray_char, [10] overflowed, [15:11] zero
	output logic [cnlc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import cnlc_pkg::*;

	logic                valid_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                end_s1;
	logic                adv_s1;
	logic                out_free;

	logic [COUNT_W-1:0]  count_q;
	logic [SUM_W-1:0]    sum_even_q;
	logic [SUM_W-1:0]    sum_odd_q;
	logic [PREFIX_W-1:0] prefix_q;
	logic                non_digit_q;
	logic                overflow_q;

	logic                m_tvalid_q;
	result_t             result_q;
	result_t             result_d;

	logic                is_digit;
	logic [SUM_W-1:0]    digit_v;
	logic [SUM_W-1:0]    sel_sum;
	logic                valid_d;

	// handshake: an end request waits only for a free result register
	assign out_free = !m_tvalid_q || m_tready;
	assign adv_s1   = valid_s1 && (!end_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	// character decode
	assign is_digit = (char_s1 >= 8'h30) && (char_s1 <= 8'h39);
	assign digit_v  = SUM_W'(char_s1 - 8'h30);

	// running state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_even_q  <= '0;
			sum_odd_q   <= '0;
			prefix_q    <= '0;
			non_digit_q <= 1'b0;
			overflow_q  <= 1'b0;
		end else if (adv_s1) begin
			if (end_s1) begin
				count_q     <= '0;
				sum_even_q  <= '0;
				sum_odd_q   <= '0;
				prefix_q    <= '0;
				non_digit_q <= 1'b0;
				overflow_q  <= 1'b0;
			end else if (!overflow_q) begin
				if (count_q >= COUNT_W'(MAX_DIGITS)) begin
					overflow_q <= 1'b1;
				end else if (is_digit) begin
					if (!count_q[0]) begin
						sum_even_q <= add_mod10(sum_even_q, dbl_digit(digit_v));
						sum_odd_q  <= add_mod10(sum_odd_q, digit_v);
					end else begin
						sum_odd_q  <= add_mod10(sum_odd_q, dbl_digit(digit_v));
						sum_even_q <= add_mod10(sum_even_q, digit_v);
					end
					if (count_q < COUNT_W'(PREFIX_DIGITS)) begin
						prefix_q <= (prefix_q << 3) + (prefix_q << 1) + PREFIX_W'(digit_v);
					end
					count_q <= count_q + COUNT_W'(1);
				end else if (!is_skip(char_s1)) begin
					non_digit_q <= 1'b1;
				end
			end
		end
	end

	// result at the end marker
	assign sel_sum = count_q[0] ? sum_odd_q : sum_even_q;
	assign valid_d = !overflow_q && len_ok(count_q) && (sel_sum == '0);

	always_comb begin
		result_d              = '0;
		result_d.num_digits   = count_q;
		result_d.check_ok     = valid_d;
		result_d.network_code = valid_d ? detect_network(count_q, prefix_q) : NET_UNKNOWN;
		result_d.stray_char   = non_digit_q;
		result_d.overflowed   = overflow_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= adv_s1 && end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && end_s1) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = result_q;

`ifndef SYNTHESIS
	// digit count never passes the store limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_DIGITS))
		else $error("digit count beyond store limit");

	// overflow only with a full store
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> count_q == COUNT_W'(MAX_DIGITS))
		else $error("overflow without full store");

	// running sums stay decimal digits
	a_sum_digit: assert property (@(posedge clk) disable iff (!arst_n)
		sum_even_q < 4'd10 && sum_odd_q < 4'd10)
		else $error("luhn sum out of range");

	// state is cleared after an end request
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && end_s1 |=> count_q == '0 && !overflow_q && !non_digit_q)
		else $error("state not cleared after end");

	// a known network only with a passing check
	a_net_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && result_q.network_code != NET_UNKNOWN |-> result_q.check_ok)
		else $error("network without luhn pass");
`endif

endmodule

### bench/card_number_luhn_classifier_checker.sv
`timescale 1ns / 100ps
// checker for card_number_luhn_classifier_core: follows both streams and predicts each result
// compares every result field by field; depends on cnlc_pkg
module card_number_luhn_classifier_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [cnlc_pkg::CHAR_W-1:0]      s_tdata,  // [7:0] character
	input  logic                             s_tlast,  // end of string
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// [4:0] num_digits, [5] check_ok, [8:6] network_code,
	// [9] stray_char, [10] overflowed, [15:11] zero
	input  logic [cnlc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                               mismatches,
	output int                               pending,
	output int                               cards_checked,
	output int                               cards_valid
);
	import cnlc_pkg::*;

	// byte codes the classifier treats specially
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// predicted state of the string being read
	logic [COUNT_W-1:0]  card_count;
	logic [SUM_W-1:0]    sum_even;
	logic [SUM_W-1:0]    sum_odd;
	logic [PREFIX_W-1:0] lead_digits;
	logic                stray_seen;
	logic                full_seen;

	result_t expected_cards[$];
	int      fault_total = 0;
	int      checked_total = 0;
	int      valid_total = 0;

	// doubled digit with nine taken off above nine
	function automatic logic [SUM_W-1:0] luhn_twice(input logic [SUM_W-1:0] v);
		int x;
		x = 2 * int'(v);
		return (x > 9) ? SUM_W'(x - 9) : SUM_W'(x);
	endfunction

	function automatic logic [SUM_W-1:0] plus_mod10(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		return SUM_W'((int'(a) + int'(b)) % 10);
	endfunction

	// issuer from length and the first six digits, first matching rule wins
	function automatic network_t issuer_of(input int len, input int lead6);
		int p1;
		int p2;
		int p3;
		int p4;
		p1 = lead6 / 100000;
		p2 = lead6 / 10000;
		p3 = lead6 / 1000;
		p4 = lead6 / 100;
		if (len == 15 && (p2 == 34 || p2 == 37))
			return NET_AMEX;
		if ((len == 13 || len == 16 || len == 19) && p1 == 4)
			return NET_VISA;
		if (len == 16 && ((p2 >= 51 && p2 <= 55) || (p4 >= 2221 && p4 <= 2720)))
			return NET_MASTERCARD;
		if ((len == 16 || len == 19) && (p4 == 6011 || p2 == 65 ||
			(p3 >= 644 && p3 <= 649) || (lead6 >= 622126 && lead6 <= 622925)))
			return NET_DISCOVER;
		return NET_UNKNOWN;
	endfunction

	task automatic clear_card();
		card_count  = '0;
		sum_even    = '0;
		sum_odd     = '0;
		lead_digits = '0;
		stray_seen  = 1'b0;
		full_seen   = 1'b0;
	endtask

	// fold one character into the running sums and flags
	task automatic take_char(input logic [7:0] c);
		logic [SUM_W-1:0] v;
		if (full_seen) begin
			return;
		end
		if (card_count >= COUNT_W'(MAX_DIGITS)) begin
			full_seen = 1'b1;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			v = SUM_W'(c - CH_ZERO);
			if (!card_count[0]) begin
				sum_even = plus_mod10(sum_even, luhn_twice(v));
				sum_odd  = plus_mod10(sum_odd, v);
			end else begin
				sum_odd  = plus_mod10(sum_odd, luhn_twice(v));
				sum_even = plus_mod10(sum_even, v);
			end
			if (card_count < COUNT_W'(PREFIX_DIGITS)) begin
				lead_digits = PREFIX_W'(int'(lead_digits) * 10 + int'(v));
			end
			card_count = card_count + 1'b1;
		end else if (!(c == CH_SPACE || c == CH_HYPHEN || (c >= CH_TAB && c <= CH_CR))) begin
			stray_seen = 1'b1;
		end
	endtask

	// result of the end request, then back to an empty string
	task automatic close_card(output result_t res);
		int               n;
		logic [SUM_W-1:0] parity_sum;
		n = int'(card_count);
		res = '0;
		res.num_digits   = card_count;
		res.stray_char   = stray_seen;
		res.overflowed   = full_seen;
		res.network_code = NET_UNKNOWN;
		if (n != 0 && !full_seen && (n == 13 || n == 15 || n == 16 || n == 19)) begin
			parity_sum = card_count[0] ? sum_odd : sum_even;
			res.check_ok = (parity_sum == '0);
			if (res.check_ok) begin
				res.network_code = issuer_of(n, int'(lead_digits));
			end
		end
		clear_card();
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fault_total++;
		end
	endtask

	// results are taken before requests: a result never answers a same-edge request
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		result_t res;
		if (!arst_n) begin
			clear_card();
			expected_cards.delete();
			pending       <= 0;
			mismatches    <= fault_total;
			cards_checked <= checked_total;
			cards_valid   <= valid_total;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_cards.size() == 0) begin
					$display("%0t: result with none expected, expected nothing, actual %h",
						$time, m_tdata);
					fault_total++;
				end else begin
					want = expected_cards.pop_front();
					compare_field("num_digits", want.num_digits, got.num_digits);
					compare_field("check_ok", want.check_ok, got.check_ok);
					compare_field("network_code", want.network_code, got.network_code);
					compare_field("stray_char", want.stray_char, got.stray_char);
					compare_field("overflowed", want.overflowed, got.overflowed);
					compare_field("pad", 0, got.pad);
					checked_total++;
					if (want.check_ok) begin
						valid_total++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tlast) begin
					close_card(res);
					expected_cards.push_back(res);
				end else begin
					take_char(s_tdata);
				end
			end
			pending       <= expected_cards.size();
			mismatches    <= fault_total;
			cards_checked <= checked_total;
			cards_valid   <= valid_total;
		end
	end

endmodule

### bench/card_number_luhn_classifier_core_tb.sv
`timescale 1ns / 100ps
// testbench top for card_number_luhn_classifier_core: card strings with random gaps and stalls
// depends on cnlc_pkg, the core and card_number_luhn_classifier_checker
module card_number_luhn_classifier_core_tb;
	import cnlc_pkg::*;

	localparam int ITEM_GOAL      = 1050;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// whitespace and hyphen, skipped by the block
	localparam logic [7:0] SEPARATORS [7] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h2D};
	// non-digits next to the digit and separator codes, and the lowest and highest byte codes
	localparam logic [7:0] NEAR_DIGITS [8] = '{8'h00, 8'h08, 8'h0E, 8'h1F, 8'h2F, 8'h3A,
		8'h2C, 8'hFF};

	typedef enum int {CHECK_ANY, CHECK_GOOD, CHECK_BAD} check_mode_t;
	typedef enum int {ISS_VISA, ISS_AMEX, ISS_MC5, ISS_MC2, ISS_DISCOVER, ISS_OTHER} issuer_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [CHAR_W-1:0]      s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int mismatches;
	int pending;
	int cards_checked;
	int cards_valid;

	bit         idle_on = 1'b1;
	logic [7:0] line_q[$];
	int         chars_sent = 0;
	int         strings_sent = 0;
	int         quiet_cycles = 0;

	card_number_luhn_classifier_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	card_number_luhn_classifier_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.mismatches    (mismatches),
		.pending       (pending),
		.cards_checked (cards_checked),
		.cards_valid   (cards_valid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one request on the input side, optionally after an idle gap
	task automatic offer_char(input logic [7:0] c, input logic last_flag);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last_flag;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
	endtask

	// send the queued characters, then the end marker
	task automatic play_line();
		foreach (line_q[i]) begin
			offer_char(line_q[i], 1'b0);
		end
		offer_char(8'($urandom_range(0, 255)), 1'b1);
		line_q.delete();
		strings_sent++;
	endtask

	// digits after a fixed lead, check digit as asked, separators sprinkled in
	task automatic build_card(input string lead, input int len, input check_mode_t mode,
		input int sep_pct);
		int d[$];
		int s;
		int x;
		for (int i = 0; i < len; i++) begin
			d.push_back(i < lead.len() ? int'(lead.getc(i)) - int'(CH_ZERO) :
				$urandom_range(0, 9));
		end
		if (mode != CHECK_ANY && len > 0) begin
			s = 0;
			for (int i = 0; i < len - 1; i++) begin
				x = ((len - 1 - i) % 2 == 1) ? 2 * d[i] : d[i];
				s += (x > 9) ? x - 9 : x;
			end
			d[len-1] = (10 - s % 10) % 10;
			if (mode == CHECK_BAD) begin
				d[len-1] = (d[len-1] + $urandom_range(1, 9)) % 10;
			end
		end
		foreach (d[i]) begin
			if ($urandom_range(0, 99) < sep_pct) begin
				line_q.push_back(SEPARATORS[$urandom_range(0, 6)]);
			end
			line_q.push_back(CH_ZERO + 8'(d[i]));
		end
	endtask

	// card of a given issuer, prefixes drawn up to one past each range but Visa's
	task automatic build_issuer_card(input issuer_t iss);
		string lead;
		int    len;
		int    lens[4];
		check_mode_t mode;
		lens = '{13, 15, 16, 19};
		case (iss)
			ISS_VISA: begin
				lead = "4";
				len = lens[$urandom_range(0, 3)];
			end
			ISS_AMEX: begin
				lead = $sformatf("%0d", $urandom_range(33, 38));
				len = 15;
			end
			ISS_MC5: begin
				lead = $sformatf("%0d", $urandom_range(50, 56));
				len = 16;
			end
			ISS_MC2: begin
				lead = $sformatf("%0d", $urandom_range(2220, 2721));
				len = 16;
			end
			ISS_DISCOVER: begin
				case ($urandom_range(0, 3))
					0: lead = $sformatf("%0d", $urandom_range(6010, 6012));
					1: lead = $sformatf("%0d", $urandom_range(64, 66));
					2: lead = $sformatf("%0d", $urandom_range(643, 650));
					default: lead = $sformatf("%0d", $urandom_range(622125, 622926));
				endcase
				len = $urandom_range(0, 1) ? 16 : 19;
			end
			default: begin
				lead = $sformatf("%0d", $urandom_range(100000, 999999));
				len = lens[$urandom_range(0, 3)];
			end
		endcase
		// now and then a length the issuer does not use
		if ($urandom_range(0, 9) == 0) begin
			len = lens[$urandom_range(0, 3)];
		end else if ($urandom_range(0, 19) == 0) begin
			len = $urandom_range(0, 19);
		end
		mode = ($urandom_range(0, 99) < 85) ? CHECK_GOOD : CHECK_ANY;
		build_card(lead, len, mode, $urandom_range(0, 1) ? 0 : 20);
	endtask

	task automatic random_string();
		int k;
		int n;
		k = $urandom_range(0, 99);
		if (k < 60) begin
			build_issuer_card(issuer_t'($urandom_range(0, 5)));
		end else if (k < 72) begin
			// store full, then a few bytes of any kind
			build_card("", 19, CHECK_ANY, $urandom_range(0, 1) ? 0 : 15);
			n = $urandom_range(1, 4);
			repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
		end else if (k < 87) begin
			// noise: any bytes, digits somewhat favored
			n = $urandom_range(0, 20);
			repeat (n) begin
				line_q.push_back($urandom_range(0, 1) ? CH_ZERO + 8'($urandom_range(0, 9)) :
					8'($urandom_range(0, 255)));
			end
		end else begin
			// well-formed card broken by one stray byte
			build_issuer_card(issuer_t'($urandom_range(0, 5)));
			line_q.insert($urandom_range(0, line_q.size()), 8'($urandom_range(0, 255)));
		end
		play_line();
	endtask

	// result side: random stall before each result, sometimes none
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// watchdog on cycles without any request or result taken
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : stimulus
		string leads[6];
		int    lens[6];
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty string, then Luhn-good cards on issuer range edges, some at lengths off the rules
		play_line();
		leads = '{"4", "4", "4", "34", "37", "51"};
		lens  = '{16, 13, 19, 15, 15, 16};
		foreach (leads[i]) begin
			build_card(leads[i], lens[i], CHECK_GOOD, (i == 0) ? 40 : 0);
			play_line();
		end
		leads = '{"55", "2221", "2720", "6011", "65", "644"};
		lens  = '{16, 16, 16, 16, 19, 16};
		foreach (leads[i]) begin
			build_card(leads[i], lens[i], CHECK_GOOD, 0);
			play_line();
		end
		leads = '{"649", "622126", "622925", "34", "2720", "4"};
		lens  = '{19, 16, 19, 16, 19, 14};
		foreach (leads[i]) begin
			build_card(leads[i], lens[i], CHECK_GOOD, 0);
			play_line();
		end
		// luhn failure and a single digit
		build_card("4", 16, CHECK_BAD, 0);
		play_line();
		build_card("0", 1, CHECK_ANY, 0);
		play_line();
		// every separator, no flag expected
		foreach (SEPARATORS[i]) line_q.push_back(SEPARATORS[i]);
		build_card("5", 16, CHECK_GOOD, 0);
		play_line();
		// digit store full: one more digit, then a non-digit that must not set the flag
		build_card("", 19, CHECK_ANY, 0);
		line_q.push_back(CH_ZERO + 8'd5);
		play_line();
		build_card("9", 19, CHECK_GOOD, 0);
		line_q.push_back(8'h78);
		play_line();
		// each byte near the digits and separators, and the lowest and highest, sets the flag
		foreach (NEAR_DIGITS[i]) begin
			line_q.push_back(CH_ZERO + 8'd7);
			line_q.push_back(NEAR_DIGITS[i]);
			play_line();
		end

		// random strings, idling switched on and off in stretches
		while (chars_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 5) == 0) begin
				idle_on = ~idle_on;
			end
			random_string();
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d strings in %0d requests: all issuers, range edges, overflow, noise",
			strings_sent, chars_sent);
		$display("checked %0d results, %0d of them luhn-valid", cards_checked, cards_valid);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
